@@ hdl/isrt_pkg.sv @@
package isrt_pkg;

  localparam int TAG_WIDTH  = 16;
  localparam int FKEY_WIDTH = 16;

  // register map (byte addresses)
  localparam logic ADDR_DESCENDING = 1'b0;

  // shared control for every cell of the chain
  typedef struct packed {
    logic load;        // insert the broadcast item this cycle
    logic drain;       // move every entry one cell toward the head
    logic descending;  // current sort direction
  } isrt_ctrl_t;

endpackage

@@ hdl/isrt_cell.sv @@
module isrt_cell #(
  parameter int KW = 16
) (
  input  logic                        clk,
  input  isrt_pkg::isrt_ctrl_t        ctrl,
  input  logic                        slot_valid,
  input  logic                        slot_free,
  input  logic [KW-1:0]               new_key,
  input  logic [isrt_pkg::TAG_WIDTH-1:0] new_tag,
  input  logic                        left_shift,
  input  logic [KW-1:0]               left_key,
  input  logic [isrt_pkg::TAG_WIDTH-1:0] left_tag,
  input  logic [KW-1:0]               right_key,
  input  logic [isrt_pkg::TAG_WIDTH-1:0] right_tag,
  output logic                        shift_out,
  output logic [KW-1:0]               key,
  output logic [isrt_pkg::TAG_WIDTH-1:0] tag
);

  logic hit;

  // new item goes strictly before this entry; ties stay behind
  assign hit = slot_valid &
               (ctrl.descending ? (new_key > key) : (new_key < key));

  // once an earlier cell took the item, every later cell moves one place down
  assign shift_out = left_shift | hit;

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      if (left_shift) begin
        key <= left_key;
        tag <= left_tag;
      end else if (hit || slot_free) begin
        key <= new_key;
        tag <= new_tag;
      end
    end else if (ctrl.drain) begin
      key <= right_key;
      tag <= right_tag;
    end
  end

endmodule

@@ hdl/insertion_sorter_core.sv @@
// Stable insertion sorter.
// Input channel (in_valid/in_ready): one beat carries sort_key, record_tag
// and last_item. Each beat is inserted into a chain of DEPTH cells, after
// every entry with an equal key, so ties keep arrival order. The item is
// compared against every stored entry in the same cycle, so the loading
// phase takes one beat per cycle.
// Output channel (out_valid/out_ready): a beat with last_item starts a run
// of results, one per stored entry, in sorted order. The first result is
// valid the cycle after the last input beat; the chain then shifts toward
// its head by one cell per taken result. out_last marks the final result;
// dropped is set on every result of a run whose set overflowed the chain.
// in_ready is low from the last input beat until the final result is taken.
// A stall on out_ready simply holds the head cell; nothing is lost.
// Register descending (APB byte address 0): 0 gives smallest key first,
// 1 largest first. Write it only while the block is idle.
// Reset (rst, synchronous) empties the chain, clears the overflow flag and
// the direction register. No clearing pass is needed.
module insertion_sorter_core #(
  parameter int DEPTH     = 16,
  parameter int KEY_WIDTH = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  // configuration
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic                                paddr,
  input  logic [31:0]                         pwdata,
  output logic [31:0]                         prdata,
  output logic                                pready,
  // input channel
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [isrt_pkg::FKEY_WIDTH-1:0]     sort_key,
  input  logic [isrt_pkg::TAG_WIDTH-1:0]      record_tag,
  input  logic                                last_item,
  // output channel
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [isrt_pkg::FKEY_WIDTH-1:0]     out_key,
  output logic [isrt_pkg::TAG_WIDTH-1:0]      out_tag,
  output logic                                out_last,
  output logic                                dropped
);

  localparam int KW = (KEY_WIDTH < isrt_pkg::FKEY_WIDTH) ? KEY_WIDTH
                                                         : isrt_pkg::FKEY_WIDTH;
  localparam int FW = $clog2(DEPTH + 1);
  localparam logic [FW-1:0] FILL_FULL = FW'(DEPTH);
  localparam logic [FW-1:0] FILL_ONE  = FW'(1);

  logic                descending;
  logic [FW-1:0]       fill;
  logic [FW-1:0]       fill_next;
  logic                overflow;
  logic                overflow_next;
  logic                draining;
  logic                draining_next;
  logic                in_fire;
  logic                out_fire;
  logic                full;
  logic                cfg_write;
  logic [KW-1:0]       new_key;
  isrt_pkg::isrt_ctrl_t ctrl;

  logic [KW-1:0]                    cell_key   [DEPTH];
  logic [isrt_pkg::TAG_WIDTH-1:0]   cell_tag   [DEPTH];
  logic [DEPTH-1:0]                 cell_shift;

  // configuration port
  assign pready    = 1'b1;
  assign cfg_write = psel & penable & pwrite & pready & (paddr == isrt_pkg::ADDR_DESCENDING);
  assign prdata    = (paddr == isrt_pkg::ADDR_DESCENDING) ? {31'b0, descending} : 32'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      descending <= 1'b0;
    end else if (cfg_write) begin
      descending <= pwdata[0];
    end
  end

  // handshakes
  assign in_ready  = ~draining;
  assign in_fire   = in_valid & in_ready;
  assign out_valid = draining;
  assign out_fire  = out_valid & out_ready;
  assign full      = (fill == FILL_FULL);
  assign new_key   = sort_key[KW-1:0];

  assign ctrl.load       = in_fire & ~full;
  assign ctrl.drain      = out_fire;
  assign ctrl.descending = descending;

  always_comb begin
    fill_next     = fill;
    overflow_next = overflow;
    draining_next = draining;
    if (in_fire) begin
      if (full) begin
        overflow_next = 1'b1;
      end else begin
        fill_next = fill + FILL_ONE;
      end
      if (last_item) begin
        draining_next = 1'b1;
      end
    end else if (out_fire) begin
      fill_next = fill - FILL_ONE;
      if (out_last) begin
        draining_next = 1'b0;
        overflow_next = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill     <= '0;
      overflow <= 1'b0;
      draining <= 1'b0;
    end else begin
      fill     <= fill_next;
      overflow <= overflow_next;
      draining <= draining_next;
    end
  end

  // chain of cells
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic                           l_shift;
    logic [KW-1:0]                  l_key;
    logic [isrt_pkg::TAG_WIDTH-1:0] l_tag;
    logic [KW-1:0]                  r_key;
    logic [isrt_pkg::TAG_WIDTH-1:0] r_tag;

    if (i == 0) begin : g_head
      assign l_shift = 1'b0;
      assign l_key   = new_key;
      assign l_tag   = record_tag;
    end else begin : g_body
      assign l_shift = cell_shift[i-1];
      assign l_key   = cell_key[i-1];
      assign l_tag   = cell_tag[i-1];
    end

    if (i == DEPTH - 1) begin : g_tail
      assign r_key = cell_key[i];
      assign r_tag = cell_tag[i];
    end else begin : g_mid
      assign r_key = cell_key[i+1];
      assign r_tag = cell_tag[i+1];
    end

    isrt_cell #(
      .KW (KW)
    ) u_cell (
      .clk        (clk),
      .ctrl       (ctrl),
      .slot_valid (FW'(i) < fill),
      .slot_free  (FW'(i) == fill),
      .new_key    (new_key),
      .new_tag    (record_tag),
      .left_shift (l_shift),
      .left_key   (l_key),
      .left_tag   (l_tag),
      .right_key  (r_key),
      .right_tag  (r_tag),
      .shift_out  (cell_shift[i]),
      .key        (cell_key[i]),
      .tag        (cell_tag[i])
    );
  end

  // head cell feeds the output channel
  assign out_key  = isrt_pkg::FKEY_WIDTH'(cell_key[0]);
  assign out_tag  = cell_tag[0];
  assign out_last = (fill == FILL_ONE);
  assign dropped  = overflow;

`ifndef SYNTHESIS
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= FILL_FULL)
    else $error("fill count above depth");

  a_drain_nonempty: assert property (@(posedge clk) disable iff (rst)
    draining |-> (fill != '0))
    else $error("draining an empty chain");

  a_run_end: assert property (@(posedge clk) disable iff (rst)
    (out_fire && out_last) |=> (fill == '0) && !draining && !overflow)
    else $error("chain not emptied after final result");

  a_insert_count: assert property (@(posedge clk) disable iff (rst)
    (in_fire && !full) |=> (fill == $past(fill) + FILL_ONE))
    else $error("insert did not advance fill count");

  a_drop_flag: assert property (@(posedge clk) disable iff (rst)
    (in_fire && full) |=> overflow)
    else $error("overflow not flagged on full chain");
`endif

endmodule
